/* src/hrte_pkg.sv */
`timescale 1ns / 1ps

package hrte_pkg;

   // Input item kinds carried on tuser.
   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_DATA = 2'd1;
   localparam logic [1:0] MODE_END  = 2'd2;

   localparam int MODE_W  = 2;
   localparam int IDX_W   = 9;
   localparam int CODE_W  = 32;
   localparam int TLEN_W  = 6;
   localparam int BYTE_W  = 8;
   localparam int RUN_W   = 15;
   localparam int EXT_W   = 14;
   localparam int EXTL_W  = 4;

   localparam int TABLE_DEPTH = 261;

   // Run class entries.
   localparam logic [IDX_W-1:0] IDX_RUN1    = 9'd0;
   localparam logic [IDX_W-1:0] IDX_RUN2    = 9'd256;
   localparam logic [IDX_W-1:0] IDX_RUN3_6  = 9'd257;
   localparam logic [IDX_W-1:0] IDX_RUN7_22 = 9'd258;
   localparam logic [IDX_W-1:0] IDX_RUN23   = 9'd259;
   localparam logic [IDX_W-1:0] IDX_RUN279  = 9'd260;
   localparam logic [IDX_W-1:0] IDX_LAST    = 9'd260;

   // Class bases for the extra count field.
   localparam logic [RUN_W-1:0] RUN_BASE_3   = 15'd3;
   localparam logic [RUN_W-1:0] RUN_BASE_7   = 15'd7;
   localparam logic [RUN_W-1:0] RUN_BASE_23  = 15'd23;
   localparam logic [RUN_W-1:0] RUN_BASE_279 = 15'd279;

   typedef struct packed {
      logic [IDX_W-1:0]  idx;
      logic [EXT_W-1:0]  ext;
      logic [EXTL_W-1:0] ext_len;
   } run_class_type;

endpackage

/* src/hrte_front.sv */
`timescale 1ns / 1ps

module hrte_front #(
   parameter int MAX_CODE_BITS = 32,
   parameter int MAX_ZERO_RUN  = 16662
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [hrte_pkg::MODE_W-1:0]            mode,
   input  logic [hrte_pkg::IDX_W-1:0]             table_index,
   input  logic [hrte_pkg::CODE_W-1:0]            table_code,
   input  logic [hrte_pkg::TLEN_W-1:0]            table_length,
   input  logic [hrte_pkg::BYTE_W-1:0]            data_byte,
   input  logic                                   q_full,
   output logic                                   q_push,
   output logic [2*MAX_CODE_BITS+hrte_pkg::EXT_W
                 +$clog2(2*MAX_CODE_BITS+hrte_pkg::EXT_W+1):0] q_data
);

   localparam int CHUNK_W = 2*MAX_CODE_BITS + hrte_pkg::EXT_W;
   localparam int CLEN_W  = $clog2(CHUNK_W + 1);
   localparam int ENT_W   = MAX_CODE_BITS + hrte_pkg::TLEN_W;
   localparam int RB_W    = MAX_CODE_BITS + hrte_pkg::EXT_W;
   localparam int RUN_W   = hrte_pkg::RUN_W;

   function automatic hrte_pkg::run_class_type classify(input logic [RUN_W-1:0] n);
      hrte_pkg::run_class_type c;
      logic [RUN_W-1:0] d;
      begin
         c = '0;
         d = '0;
         if (n == RUN_W'(1)) begin
            c.idx = hrte_pkg::IDX_RUN1;
         end else if (n == RUN_W'(2)) begin
            c.idx = hrte_pkg::IDX_RUN2;
         end else if (n <= RUN_W'(6)) begin
            d = n - hrte_pkg::RUN_BASE_3;
            c.idx = hrte_pkg::IDX_RUN3_6;
            c.ext_len = hrte_pkg::EXTL_W'(2);
         end else if (n <= RUN_W'(22)) begin
            d = n - hrte_pkg::RUN_BASE_7;
            c.idx = hrte_pkg::IDX_RUN7_22;
            c.ext_len = hrte_pkg::EXTL_W'(4);
         end else if (n <= RUN_W'(278)) begin
            d = n - hrte_pkg::RUN_BASE_23;
            c.idx = hrte_pkg::IDX_RUN23;
            c.ext_len = hrte_pkg::EXTL_W'(8);
         end else begin
            d = n - hrte_pkg::RUN_BASE_279;
            c.idx = hrte_pkg::IDX_RUN279;
            c.ext_len = hrte_pkg::EXTL_W'(14);
         end
         c.ext = d[hrte_pkg::EXT_W-1:0];
         return c;
      end
   endfunction

   logic [ENT_W-1:0] table_mem [hrte_pkg::TABLE_DEPTH];

   logic                         accept;
   logic                         is_load;
   logic                         is_data;
   logic                         is_end;
   logic                         is_zero;
   logic [hrte_pkg::TLEN_W-1:0]  len_sat;
   logic [MAX_CODE_BITS-1:0]     code_msk;
   logic [RUN_W-1:0]             run_ff;
   logic [RUN_W-1:0]             run_in;
   logic [RUN_W-1:0]             run_next;
   logic [RUN_W-1:0]             close_cnt;
   logic                         close_run;
   hrte_pkg::run_class_type      cls;

   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_run_ff;
   logic                         s1_byte_ff;
   logic                         s1_end_ff;
   logic [hrte_pkg::EXT_W-1:0]   s1_ext_ff;
   logic [hrte_pkg::EXTL_W-1:0]  s1_ext_len_ff;
   logic [ENT_W-1:0]             rd_run_ff;
   logic [ENT_W-1:0]             rd_byte_ff;

   logic [MAX_CODE_BITS-1:0]     run_code;
   logic [hrte_pkg::TLEN_W-1:0]  run_len;
   logic [MAX_CODE_BITS-1:0]     byte_code;
   logic [hrte_pkg::TLEN_W-1:0]  byte_len;
   logic [RB_W-1:0]              run_bits;
   logic [CLEN_W-1:0]            run_tot;
   logic [CHUNK_W-1:0]           chunk;
   logic [CLEN_W-1:0]            chunk_len;

   assign req_ready = !s1_valid_ff || !q_full;
   assign accept    = req_valid && req_ready;
   assign is_load   = mode == hrte_pkg::MODE_LOAD;
   assign is_data   = mode == hrte_pkg::MODE_DATA;
   assign is_end    = mode == hrte_pkg::MODE_END;
   assign is_zero   = data_byte == '0;

   // Saturate the length and drop code bits beyond it.
   always_comb begin
      len_sat = (table_length > hrte_pkg::TLEN_W'(MAX_CODE_BITS)) ?
                hrte_pkg::TLEN_W'(MAX_CODE_BITS) : table_length;
      for (int i = 0; i < MAX_CODE_BITS; i++) begin
         code_msk[i] = table_code[i] && (i < int'(len_sat));
      end
   end

   always_comb begin
      run_next  = run_ff + RUN_W'(1);
      close_cnt = (is_data && is_zero) ? run_next : run_ff;
      if (is_data && is_zero) begin
         close_run = run_next >= RUN_W'(MAX_ZERO_RUN);
      end else if (is_data || is_end) begin
         close_run = run_ff != '0;
      end else begin
         close_run = 1'b0;
      end
      cls = classify(close_cnt);
      run_in = run_ff;
      if (accept && is_data && is_zero) begin
         run_in = close_run ? '0 : run_next;
      end else if (accept && (is_data || is_end)) begin
         run_in = '0;
      end
      s1_valid_in = accept ? ((is_data && (close_run || !is_zero)) || is_end) :
                    (s1_valid_ff && q_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         run_ff      <= run_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Table write and both registered reads happen at the accepting edge.
   always_ff @(posedge clock) begin
      if (accept) begin
         if (is_load && table_index <= hrte_pkg::IDX_LAST) begin
            table_mem[table_index] <= {len_sat, code_msk};
         end
         rd_run_ff     <= table_mem[cls.idx];
         rd_byte_ff    <= table_mem[{1'b0, data_byte}];
         s1_run_ff     <= close_run;
         s1_byte_ff    <= is_data && !is_zero;
         s1_end_ff     <= is_end;
         s1_ext_ff     <= close_run ? cls.ext : '0;
         s1_ext_len_ff <= close_run ? cls.ext_len : '0;
      end
   end

   // Merge run code, extra count and byte code into one chunk, LSB first.
   always_comb begin
      run_code  = s1_run_ff ? rd_run_ff[MAX_CODE_BITS-1:0] : '0;
      run_len   = s1_run_ff ? rd_run_ff[ENT_W-1:MAX_CODE_BITS] : '0;
      byte_code = s1_byte_ff ? rd_byte_ff[MAX_CODE_BITS-1:0] : '0;
      byte_len  = s1_byte_ff ? rd_byte_ff[ENT_W-1:MAX_CODE_BITS] : '0;
      run_bits  = RB_W'(run_code) | (RB_W'(s1_ext_ff) << run_len);
      run_tot   = CLEN_W'(run_len) + CLEN_W'(s1_ext_len_ff);
      chunk     = CHUNK_W'(run_bits) | (CHUNK_W'(byte_code) << run_tot);
      chunk_len = run_tot + CLEN_W'(byte_len);
   end

   assign q_push = s1_valid_ff && !q_full;
   assign q_data = {s1_end_ff, chunk_len, chunk};

endmodule

/* src/hrte_fifo.sv */
`timescale 1ns / 1ps

module hrte_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] dout
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign full    = cnt_ff == CNT_W'(DEPTH);
   assign valid   = cnt_ff != '0;
   assign dout    = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= din;
      end
   end

endmodule

/* src/hrte_packer.sv */
`timescale 1ns / 1ps

module hrte_packer #(
   parameter int CHUNK_W = 78
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  logic [CHUNK_W+$clog2(CHUNK_W+1):0] q_data,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [hrte_pkg::BYTE_W-1:0]      rsp_byte,
   output logic                             rsp_last
);

   localparam int CLEN_W = $clog2(CHUNK_W + 1);
   localparam int ACC_W  = CHUNK_W + 7;
   localparam int CNT_W  = $clog2(ACC_W + 1);

   logic [CHUNK_W-1:0] head_chunk;
   logic [CLEN_W-1:0]  head_len;
   logic               head_end;

   logic [ACC_W-1:0]   acc_ff, acc_in, acc_a;
   logic [CNT_W-1:0]   cnt_ff, cnt_in, cnt_a;
   logic               flush_ff, flush_in, flush_a;
   logic               out_free;
   logic               emit;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [hrte_pkg::BYTE_W-1:0] rsp_byte_ff;
   logic                        rsp_last_ff;

   assign head_chunk = q_data[CHUNK_W-1:0];
   assign head_len   = q_data[CHUNK_W+CLEN_W-1:CHUNK_W];
   assign head_end   = q_data[CHUNK_W+CLEN_W];

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      // Emit a full byte, or the padded tail while a flush is open.
      emit    = ((cnt_ff >= CNT_W'(8)) || (flush_ff && cnt_ff != '0)) && out_free;
      cnt_a   = emit ? ((cnt_ff > CNT_W'(8)) ? cnt_ff - CNT_W'(8) : '0) : cnt_ff;
      acc_a   = emit ? (acc_ff >> 8) : acc_ff;
      flush_a = flush_ff && (cnt_a != '0);
      q_pop   = q_valid && !flush_a && (cnt_a < CNT_W'(8));
      acc_in  = acc_a;
      cnt_in  = cnt_a;
      flush_in = flush_a;
      if (q_pop) begin
         acc_in   = acc_a | (ACC_W'(head_chunk) << cnt_a[2:0]);
         cnt_in   = cnt_a + CNT_W'(head_len);
         flush_in = head_end;
      end
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff <= acc_ff[hrte_pkg::BYTE_W-1:0];
         rsp_last_ff <= flush_ff && (cnt_ff <= CNT_W'(8));
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_byte  = rsp_byte_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

/* src/huffman_rle_table_encoder_core.sv */
`timescale 1ns / 1ps
// Data path: front-end lookup registers, chunk queue, packer accumulator, rsp output register.
// Throughput: one input transfer per cycle while the chunk queue has room; the packer
// drains one byte per cycle while rsp_tready is high.
// The front end stalls only when the 4-entry chunk queue is full.
// Reset (synchronous, active high) clears the run count, bit accumulator, queue and
// output valid; code table contents stay undefined until loaded.

module huffman_rle_table_encoder_core #(
   parameter int MAX_CODE_BITS = 32,
   parameter int MAX_ZERO_RUN  = 16662
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [8:0] table_index, [40:9] table_code, [46:41] table_length, [54:47] data_byte
   input  logic [55:0] req_tdata,
   // [1:0] mode
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_byte
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);

   localparam int CHUNK_W = 2*MAX_CODE_BITS + hrte_pkg::EXT_W;
   localparam int CLEN_W  = $clog2(CHUNK_W + 1);
   localparam int Q_W     = CHUNK_W + CLEN_W + 1;
   localparam int Q_DEPTH = 4;

   // Unpack the request payload.
   logic [hrte_pkg::IDX_W-1:0]  table_index;
   logic [hrte_pkg::CODE_W-1:0] table_code;
   logic [hrte_pkg::TLEN_W-1:0] table_length;
   logic [hrte_pkg::BYTE_W-1:0] data_byte;

   assign table_index  = req_tdata[8:0];
   assign table_code   = req_tdata[40:9];
   assign table_length = req_tdata[46:41];
   assign data_byte    = req_tdata[54:47];

   logic           q_push;
   logic           q_full;
   logic [Q_W-1:0] q_din;
   logic           q_valid;
   logic           q_pop;
   logic [Q_W-1:0] q_dout;

   // Front end: table load, zero-run tracking, code lookup and chunk merge.
   hrte_front #(
      .MAX_CODE_BITS (MAX_CODE_BITS),
      .MAX_ZERO_RUN  (MAX_ZERO_RUN)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .mode         (req_tuser),
      .table_index  (table_index),
      .table_code   (table_code),
      .table_length (table_length),
      .data_byte    (data_byte),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_din)
   );

   // Chunk queue: decouple lookup from byte packing.
   hrte_fifo #(
      .WIDTH (Q_W),
      .DEPTH (Q_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .full  (q_full),
      .pop   (q_pop),
      .valid (q_valid),
      .dout  (q_dout)
   );

   // Back end: accumulate chunks, emit bytes LSB first, pad and mark on flush.
   hrte_packer #(
      .CHUNK_W (CHUNK_W)
   ) u_packer (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_dout),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_byte  (rsp_tdata),
      .rsp_last  (rsp_tlast)
   );

endmodule

/* src/hrte_checker.sv */
`timescale 1ns / 1ps

module hrte_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // Output stays empty right after reset.
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // Front end is empty after reset, so it takes a transfer at once.
   a_req_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("req_tready low after reset");

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   a_rsp_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

endmodule

bind huffman_rle_table_encoder_core hrte_checker u_hrte_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
